// ===== hw/rtl/mqsb_pkg.sv =====
// ----------------------------------------------------------------------------
// mqsb_pkg: shared definitions for the multi-queue shared buffer
// Status codes, operation kinds and the command groups that the sequencer
// sends to the slot store and to the queue table.
// ----------------------------------------------------------------------------
package mqsb_pkg;

  localparam logic       KIND_ENQ = 1'b0;
  localparam logic       KIND_DEQ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;

  // Write enables for the slot store (link and data memories).
  typedef struct packed {
    logic link_we;
    logic data_we;
  } ss_cmd_t;

  // Updates to the per-queue head/tail table and its non-empty flags.
  typedef struct packed {
    logic head_we;
    logic tail_we;
    logic set_busy;
    logic clr_busy;
  } qt_cmd_t;

endpackage

// ===== hw/rtl/mqsb_slot_store.sv =====
// ----------------------------------------------------------------------------
// mqsb_slot_store: link and data memories of the shared slot pool
// One write port and one registered read port per memory; the read returns
// the old contents when the same slot is written in that cycle.
// ----------------------------------------------------------------------------
module mqsb_slot_store import mqsb_pkg::*; #(
  parameter int CAPACITY = 16,
  parameter int SW       = 4,
  parameter int PW       = 5
) (
  input  logic          clk,
  input  ss_cmd_t       cmd,
  input  logic [SW-1:0] wr_addr,
  input  logic [PW-1:0] link_wdata,
  input  logic [31:0]   data_wdata,
  input  logic [SW-1:0] rd_addr,
  output logic [PW-1:0] link_rdata,
  output logic [31:0]   data_rdata
);

  logic [PW-1:0] link_mem [CAPACITY];
  logic [31:0]   data_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (cmd.link_we) begin
      link_mem[wr_addr] <= link_wdata;
    end
    link_rdata <= link_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.data_we) begin
      data_mem[wr_addr] <= data_wdata;
    end
    data_rdata <= data_mem[rd_addr];
  end

endmodule

// ===== hw/rtl/mqsb_queue_table.sv =====
// ----------------------------------------------------------------------------
// mqsb_queue_table: head and tail slot of every queue
// Head and tail live in small memories; a non-empty flag per queue is held
// in flops so that reset empties every queue at once.
// ----------------------------------------------------------------------------
module mqsb_queue_table import mqsb_pkg::*; #(
  parameter int NUM_QUEUES = 4,
  parameter int QW         = 2,
  parameter int SW         = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  qt_cmd_t       cmd,
  input  logic [QW-1:0] wr_idx,
  input  logic [SW-1:0] head_wdata,
  input  logic [SW-1:0] tail_wdata,
  input  logic [QW-1:0] rd_idx,
  output logic [SW-1:0] head_rdata,
  output logic [SW-1:0] tail_rdata,
  output logic          busy_rdata
);

  logic [SW-1:0]         head_mem [NUM_QUEUES];
  logic [SW-1:0]         tail_mem [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] busy;

  always_ff @(posedge clk) begin
    if (cmd.head_we) begin
      head_mem[wr_idx] <= head_wdata;
    end
    if (cmd.tail_we) begin
      tail_mem[wr_idx] <= tail_wdata;
    end
    head_rdata <= head_mem[rd_idx];
    tail_rdata <= tail_mem[rd_idx];
    busy_rdata <= busy[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else begin
      if (cmd.set_busy) begin
        busy[wr_idx] <= 1'b1;
      end
      if (cmd.clr_busy) begin
        busy[wr_idx] <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/multi_queue_shared_buffer.sv =====
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer: several FIFO queues in one linked slot pool
// Enqueue and dequeue words on NUM_QUEUES queues that share CAPACITY slots,
// chained by next-slot links, with unused slots on a free list.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid, in_stall) carries one word: kind
// (0 enqueue, 1 dequeue), queue_index and push_value. The output channel
// (out_valid, out_stall) returns exactly one word per input: status and
// pop_value. pop_value is zero unless a dequeue succeeds.
// Each word is worked by a small sequencer around the single write port of
// the link memory: an error goes from acceptance through lookup and result
// load, a successful enqueue through free-slot lookup with the tail link,
// slot fill and result load, and a successful dequeue through lookup,
// dependent link read with unlink and result load. The next word is taken
// in the idle state after the result is loaded, so the block works one
// word at a time and takes no new word before that result is loaded.
// After reset the block chains all slots into the free list and holds
// in_stall high meanwhile; every queue starts empty.
// A stalled result stays in the output register; the block can accept and
// work the next word meanwhile and waits before loading its result until
// the register is taken.
// ----------------------------------------------------------------------------
module multi_queue_shared_buffer import mqsb_pkg::*; #(
  parameter int NUM_QUEUES = 4,
  parameter int CAPACITY   = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [1:0]         queue_index,
  input  logic signed [31:0] push_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] pop_value
);

  localparam int SW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [PW-1:0] NIL      = PW'(CAPACITY);
  localparam logic [SW-1:0] LAST     = SW'(CAPACITY - 1);
  localparam logic [31:0]   NQ_LIMIT = 32'(NUM_QUEUES);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_ENQ_FILL,
    S_DEQ_READ,
    S_FINISH
  } state_t;

  state_t        state;
  logic [SW-1:0] clr_cnt;
  logic [PW-1:0] free_head;
  logic          kind_r;
  logic [QW-1:0] q_r;
  logic          qok_r;
  logic [31:0]   val_r;
  logic [SW-1:0] s_r;
  logic [PW-1:0] nx_r;
  logic [1:0]    res_status;
  logic [31:0]   res_value;

  ss_cmd_t       ss_cmd;
  logic [SW-1:0] ss_wr_addr;
  logic [SW-1:0] ss_rd_addr;
  logic [PW-1:0] link_wdata;
  logic [PW-1:0] link_rdata;
  logic [31:0]   data_rdata;

  qt_cmd_t       qt_cmd;
  logic [QW-1:0] qt_rd_idx;
  logic [SW-1:0] head_wdata;
  logic [SW-1:0] qt_head;
  logic [SW-1:0] qt_tail;
  logic          qt_busy;

  logic          q_ok;
  logic          enq_go;
  logic          deq_go;
  logic          out_free;

  assign in_stall  = (state != S_IDLE);
  assign q_ok      = ({30'd0, queue_index} < NQ_LIMIT);
  assign qt_rd_idx = QW'(queue_index);
  assign enq_go    = qok_r && (free_head != NIL);
  assign deq_go    = qok_r && qt_busy;
  assign out_free  = !out_valid || !out_stall;

  mqsb_slot_store #(
    .CAPACITY (CAPACITY),
    .SW       (SW),
    .PW       (PW)
  ) u_store (
    .clk        (clk),
    .cmd        (ss_cmd),
    .wr_addr    (ss_wr_addr),
    .link_wdata (link_wdata),
    .data_wdata (val_r),
    .rd_addr    (ss_rd_addr),
    .link_rdata (link_rdata),
    .data_rdata (data_rdata)
  );

  mqsb_queue_table #(
    .NUM_QUEUES (NUM_QUEUES),
    .QW         (QW),
    .SW         (SW)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .cmd        (qt_cmd),
    .wr_idx     (q_r),
    .head_wdata (head_wdata),
    .tail_wdata (s_r),
    .rd_idx     (qt_rd_idx),
    .head_rdata (qt_head),
    .tail_rdata (qt_tail),
    .busy_rdata (qt_busy)
  );

  // Memory port steering. The link read address follows the free head
  // while idle, so the slot that an enqueue would take has its link ready
  // in the lookup cycle; a dequeue reads its head slot from the lookup.
  always_comb begin
    ss_cmd     = '0;
    qt_cmd     = '0;
    ss_wr_addr = s_r;
    link_wdata = NIL;
    head_wdata = s_r;
    ss_rd_addr = free_head[SW-1:0];
    case (state)
      S_CLEAR: begin
        ss_cmd.link_we = 1'b1;
        ss_wr_addr     = clr_cnt;
        link_wdata     = PW'(clr_cnt) + PW'(1);
      end
      S_LOOKUP: begin
        ss_rd_addr = qt_head;
        if (kind_r == KIND_ENQ && enq_go) begin
          if (qt_busy) begin
            // Append behind the current tail.
            ss_cmd.link_we = 1'b1;
            ss_wr_addr     = qt_tail;
            link_wdata     = free_head;
          end else begin
            qt_cmd.head_we  = 1'b1;
            qt_cmd.set_busy = 1'b1;
            head_wdata      = free_head[SW-1:0];
          end
        end
      end
      S_ENQ_FILL: begin
        ss_cmd.link_we = 1'b1;
        ss_cmd.data_we = 1'b1;
        link_wdata     = NIL;
        qt_cmd.tail_we = 1'b1;
      end
      S_DEQ_READ: begin
        // Push the old head slot onto the front of the free list.
        ss_cmd.link_we = 1'b1;
        link_wdata     = free_head;
        if (link_rdata == NIL) begin
          qt_cmd.clr_busy = 1'b1;
        end else begin
          qt_cmd.head_we = 1'b1;
          head_wdata     = link_rdata[SW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      free_head <= '0;
      out_valid <= 1'b0;
    end else begin
      // In the finish state the result load below decides out_valid.
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + SW'(1);
          if (clr_cnt == LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            kind_r <= kind;
            q_r    <= QW'(queue_index);
            qok_r  <= q_ok;
            val_r  <= push_value;
            state  <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          res_value <= '0;
          if (kind_r == KIND_ENQ) begin
            s_r  <= free_head[SW-1:0];
            nx_r <= link_rdata;
            if (enq_go) begin
              res_status <= ST_OK;
              state      <= S_ENQ_FILL;
            end else begin
              res_status <= ST_FULL;
              state      <= S_FINISH;
            end
          end else begin
            s_r <= qt_head;
            if (deq_go) begin
              res_status <= ST_OK;
              state      <= S_DEQ_READ;
            end else begin
              res_status <= ST_UNDER;
              state      <= S_FINISH;
            end
          end
        end
        S_ENQ_FILL: begin
          free_head <= nx_r;
          state     <= S_FINISH;
        end
        S_DEQ_READ: begin
          free_head <= PW'(s_r);
          res_value <= data_rdata;
          state     <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status    <= res_status;
            pop_value <= res_value;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The free head is always a slot or the null link.
  a_free_head_range: assert property (@(posedge clk) disable iff (rst)
    free_head <= NIL)
    else $error("free list head out of range");

  // Only defined status codes reach the output register.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_FULL || status == ST_UNDER))
    else $error("undefined status code delivered");

  // Failed operations never return data.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> pop_value == '0)
    else $error("error result carries a value");

  // A word is worked through the sequencer states: no acceptance right after one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while one is in progress");

  // A result is loaded only when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH && out_valid && out_stall |=> state == S_FINISH)
    else $error("result loaded over a stalled word");

endmodule
